// File: hw/rtl/assert_macros.svh
// shared assertion macros, sampled on clk, off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/ptpick_pkg.sv
package ptpick_pkg;

	// default table depth
	localparam int unsigned MAX_ENTRIES_DEF = 64;

	// pick tolerance after reset
	localparam logic [7:0] TOL_RESET = 8'd5;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SELECT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_ENTRY = 2'd2,
		ST_NO_HIT   = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_RESULT = 4'b1000
	} seq_state_t;

endpackage

// File: hw/rtl/point_table_pick.sv
// point table with add, remove and first-hit select, one operation at a time
// add, rejected ops and opcode 3: go straight from idle to the result state after the input transfer
// select: entries are scanned from index 0 through the registered read, one table entry compared per cycle
// remove at index i: the entries above i move down, one entry moved down per cycle
// the sequencer returns to idle as the result loads; an untaken result holds the sequencer
// reset: count 0, tolerance 5, sequencer idle; table contents undefined
module point_table_pick #(
	parameter int unsigned MAX_ENTRIES = ptpick_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // pick_tolerance
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // x_coord[15:0], y_coord[31:16], entry_index[37:32]
	input  logic [1:0]  s_axis_tuser,  // opcode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // hit_index[5:0], point_total[12:6]
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;

	// table memory, x in the upper half
	logic [31:0] mem [MAX_ENTRIES];

	ptpick_pkg::seq_state_t state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       ptr_q;
	logic [7:0]             tol_q;
	logic [15:0]            qx_q;
	logic [15:0]            qy_q;
	ptpick_pkg::status_t    status_q;
	logic [ADDR_W-1:0]      hit_q;

	logic                   pipe_vld_s1;
	logic [ADDR_W-1:0]      pipe_idx_s1;
	logic [31:0]            rd_data_s1;

	logic                   m_vld_q;
	logic [1:0]             out_status_q;
	logic [5:0]             out_hit_q;
	logic [6:0]             out_total_q;

	logic                   in_xfer;
	ptpick_pkg::op_t        in_op;
	logic [15:0]            in_x;
	logic [15:0]            in_y;
	logic [5:0]             in_idx;
	logic                   full;
	logic                   idx_bad;
	logic [CNT_W-1:0]       nxt_ptr;
	logic                   scan_issue;
	logic                   shift_issue;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [31:0]            wr_data;
	logic signed [16:0]     dx;
	logic signed [16:0]     dy;
	logic signed [16:0]     tol_s;
	logic                   hit;

	// input unpacking
	assign in_xfer = s_axis_tvalid & s_axis_tready;
	assign in_op   = ptpick_pkg::op_t'(s_axis_tuser);
	assign in_x    = s_axis_tdata[15:0];
	assign in_y    = s_axis_tdata[31:16];
	assign in_idx  = s_axis_tdata[37:32];

	assign s_axis_tready = (state_q == ptpick_pkg::S_IDLE);

	// table bounds checks
	assign full    = (cnt_q >= CNT_W'(MAX_ENTRIES));
	assign idx_bad = (CMP_W'(in_idx) >= CMP_W'(cnt_q));

	// entry pointer for scan and shift
	assign nxt_ptr     = ptr_q + CNT_W'(1);
	assign scan_issue  = (ptr_q < cnt_q);
	assign shift_issue = (nxt_ptr < cnt_q);
	assign rd_addr     = (state_q == ptpick_pkg::S_SCAN) ? ptr_q[ADDR_W-1:0]
	                                                     : nxt_ptr[ADDR_W-1:0];

	// write port: append on add, move down during shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[ADDR_W-1:0];
		wr_data = {in_x, in_y};
		if (in_xfer && in_op == ptpick_pkg::OP_ADD && !full) begin
			wr_en = 1'b1;
		end else if (state_q == ptpick_pkg::S_SHIFT && pipe_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = pipe_idx_s1;
			wr_data = rd_data_s1;
		end
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// window compare unit for the select scan
	assign dx    = signed'({qx_q[15], qx_q}) - signed'({rd_data_s1[31], rd_data_s1[31:16]});
	assign dy    = signed'({qy_q[15], qy_q}) - signed'({rd_data_s1[15], rd_data_s1[15:0]});
	assign tol_s = signed'({9'd0, tol_q});
	assign hit   = (dx <= tol_s) && (dx >= -tol_s) && (dy <= tol_s) && (dy >= -tol_s);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ptpick_pkg::TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptpick_pkg::S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			pipe_vld_s1 <= 1'b0;
			pipe_idx_s1 <= '0;
			qx_q        <= '0;
			qy_q        <= '0;
			status_q    <= ptpick_pkg::ST_DONE;
			hit_q       <= '0;
		end else begin
			case (state_q)
				ptpick_pkg::S_IDLE: begin
					if (in_xfer) begin
						qx_q        <= in_x;
						qy_q        <= in_y;
						hit_q       <= '0;
						pipe_vld_s1 <= 1'b0;
						case (in_op)
							ptpick_pkg::OP_ADD: begin
								state_q <= ptpick_pkg::S_RESULT;
								if (full) begin
									status_q <= ptpick_pkg::ST_FULL;
								end else begin
									status_q <= ptpick_pkg::ST_DONE;
									cnt_q    <= cnt_q + CNT_W'(1);
								end
							end
							ptpick_pkg::OP_REMOVE: begin
								if (idx_bad) begin
									status_q <= ptpick_pkg::ST_NO_ENTRY;
									state_q  <= ptpick_pkg::S_RESULT;
								end else begin
									ptr_q   <= CNT_W'(in_idx);
									state_q <= ptpick_pkg::S_SHIFT;
								end
							end
							ptpick_pkg::OP_SELECT: begin
								ptr_q   <= '0;
								state_q <= ptpick_pkg::S_SCAN;
							end
							default: begin
								status_q <= ptpick_pkg::ST_DONE;
								state_q  <= ptpick_pkg::S_RESULT;
							end
						endcase
					end
				end
				ptpick_pkg::S_SCAN: begin
					// one read issued, one entry checked per cycle
					pipe_vld_s1 <= scan_issue;
					pipe_idx_s1 <= ptr_q[ADDR_W-1:0];
					if (scan_issue) begin
						ptr_q <= nxt_ptr;
					end
					if (pipe_vld_s1 && hit) begin
						status_q <= ptpick_pkg::ST_DONE;
						hit_q    <= pipe_idx_s1;
						state_q  <= ptpick_pkg::S_RESULT;
					end else if (!pipe_vld_s1 && !scan_issue) begin
						status_q <= ptpick_pkg::ST_NO_HIT;
						state_q  <= ptpick_pkg::S_RESULT;
					end
				end
				ptpick_pkg::S_SHIFT: begin
					// read entry ptr+1, write it to ptr in the following cycle
					pipe_vld_s1 <= shift_issue;
					pipe_idx_s1 <= ptr_q[ADDR_W-1:0];
					if (shift_issue) begin
						ptr_q <= nxt_ptr;
					end
					if (!pipe_vld_s1 && !shift_issue) begin
						cnt_q    <= cnt_q - CNT_W'(1);
						status_q <= ptpick_pkg::ST_DONE;
						state_q  <= ptpick_pkg::S_RESULT;
					end
				end
				ptpick_pkg::S_RESULT: begin
					if (!m_vld_q || m_axis_tready) begin
						state_q <= ptpick_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ptpick_pkg::S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (state_q == ptpick_pkg::S_RESULT && (!m_vld_q || m_axis_tready)) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptpick_pkg::S_RESULT && (!m_vld_q || m_axis_tready)) begin
			out_status_q <= status_q;
			out_hit_q    <= 6'(hit_q);
			out_total_q  <= 7'(cnt_q);
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'd0, out_total_q, out_hit_q};

	// checks
	`include "assert_macros.svh"

	`CHK_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_ENTRIES))
	`CHK_IMP(a_scan_in_range, state_q == ptpick_pkg::S_SCAN && pipe_vld_s1, CNT_W'(pipe_idx_s1) < cnt_q)
	`CHK_IMP(a_shift_in_range, state_q == ptpick_pkg::S_SHIFT && pipe_vld_s1, CNT_W'(pipe_idx_s1) + CNT_W'(1) < cnt_q)
	`CHK_NEXT(a_cnt_hold, state_q == ptpick_pkg::S_SCAN || state_q == ptpick_pkg::S_RESULT, $stable(cnt_q))

endmodule
